@@ src/omr_pkg.sv @@
// Shared types, constants and the arctangent table for the omni-wheel
// odometry rotate block. Depends on nothing; every other file imports it.
package omr_pkg;

	localparam int NUM_WHEELS    = 4;
	localparam int NUM_COEF      = 2 * NUM_WHEELS;
	localparam int COEF_IDX_W    = $clog2(NUM_COEF);
	localparam int CORDIC_STAGES = 16;
	localparam int STAGE_IDX_W   = $clog2(CORDIC_STAGES);
	localparam int CFG_IDX_W     = 8;

	localparam int W_IN   = 16;
	localparam int W_PROD = 32;  // one coefficient times one wheel speed
	localparam int W_SUM  = 34;  // sum of four such products
	localparam int W_CORD = 33;  // CORDIC x, y and residual angle
	localparam int W_CS   = 19;  // rounded cosine and sine, Q3.16
	localparam int W_ROT  = W_CS + W_SUM;  // one rotation product
	localparam int W_ACC  = W_ROT + 1;     // sum of two rotation products
	localparam int W_RND  = W_ACC - 30;    // after the final shift
	localparam int W_OUT  = 20;

	localparam logic signed [W_CORD-1:0] CORDIC_K = 33'sh026DD3B6A;
	localparam logic signed [W_OUT-1:0] OUT_MAX = 20'sh7FFFF;
	localparam logic signed [W_OUT-1:0] OUT_MIN = 20'sh80000;

	typedef logic signed [W_IN-1:0] coef_t;
	typedef coef_t [NUM_COEF-1:0] coef_arr_t;

	// Entries 0 to 3 are the x row, entries 4 to 7 the y row.
	localparam coef_arr_t COEF_RESET = '{
		16'sd3476, -16'sd3476, -16'sd3476, 16'sd3476,
		16'sd3476, 16'sd3476, -16'sd3476, -16'sd3476
	};

	typedef struct packed {
		logic signed [W_IN-1:0] wheel_speed_0;
		logic signed [W_IN-1:0] wheel_speed_1;
		logic signed [W_IN-1:0] wheel_speed_2;
		logic signed [W_IN-1:0] wheel_speed_3;
		logic [W_IN-1:0]        heading;
	} in_item_t;

	typedef struct packed {
		logic signed [W_OUT-1:0] vel_x;
		logic signed [W_OUT-1:0] vel_y;
	} out_item_t;

	// What one CORDIC cell hands to the next.
	typedef struct packed {
		logic                     valid;
		logic                     flip;
		logic signed [W_CORD-1:0] x;
		logic signed [W_CORD-1:0] y;
		logic signed [W_CORD-1:0] z;
		logic signed [W_SUM-1:0]  mx;
		logic signed [W_SUM-1:0]  my;
	} cell_t;

	function automatic logic signed [W_CORD-1:0] atan_angle(input logic [STAGE_IDX_W-1:0] idx);
		logic signed [W_CORD-1:0] a;
		case (idx)
			4'd0:    a = 33'sh020000000;
			4'd1:    a = 33'sh012E4051E;
			4'd2:    a = 33'sh009FB385B;
			4'd3:    a = 33'sh0051111D4;
			4'd4:    a = 33'sh0028B0D43;
			4'd5:    a = 33'sh00145D7E1;
			4'd6:    a = 33'sh000A2F61E;
			4'd7:    a = 33'sh000517C55;
			4'd8:    a = 33'sh00028BE53;
			4'd9:    a = 33'sh000145F2F;
			4'd10:   a = 33'sh0000A2F98;
			4'd11:   a = 33'sh0000517CC;
			4'd12:   a = 33'sh000028BE6;
			4'd13:   a = 33'sh0000145F3;
			4'd14:   a = 33'sh00000A2FA;
			4'd15:   a = 33'sh00000517D;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

@@ src/omr_matrix.sv @@
// Two-stage kinematic matrix: eight products, then the two row sums, with
// the heading folded into the right half-plane for the CORDIC. Uses omr_pkg.
module omr_matrix
	import omr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_fire,
	input  in_item_t  item,
	input  coef_arr_t coef,
	output cell_t     cell_out
);

	logic                    valid_s1;
	logic signed [W_PROD-1:0] prod_s1 [NUM_COEF];
	logic [W_IN-1:0]         heading_s1;
	logic signed [W_IN-1:0]  wheel [NUM_WHEELS];
	logic [W_IN-1:0]         hsum;
	logic                    flip;
	logic [W_IN-1:0]         hfold;
	cell_t                   cell_s2;

	assign wheel[0] = item.wheel_speed_0;
	assign wheel[1] = item.wheel_speed_1;
	assign wheel[2] = item.wheel_speed_2;
	assign wheel[3] = item.wheel_speed_3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NUM_WHEELS; j++) begin
				prod_s1[j] <= coef[j] * wheel[j];
				prod_s1[j + NUM_WHEELS] <= coef[j + NUM_WHEELS] * wheel[j];
			end
			heading_s1 <= item.heading;
		end
	end

	// Headings in the left half-plane are turned half a turn; the cosine
	// and sine are negated again at the end of the chain.
	assign hsum  = heading_s1 + 16'h4000;
	assign flip  = hsum[W_IN-1];
	assign hfold = flip ? (heading_s1 ^ 16'h8000) : heading_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_s2 <= '0;
		end else if (en) begin
			cell_s2.valid <= valid_s1;
			cell_s2.flip  <= flip;
			cell_s2.x     <= CORDIC_K;
			cell_s2.y     <= '0;
			cell_s2.z     <= {hfold[W_IN-1], hfold, 16'b0};
			cell_s2.mx    <= W_SUM'(prod_s1[0]) + W_SUM'(prod_s1[1])
				+ W_SUM'(prod_s1[2]) + W_SUM'(prod_s1[3]);
			cell_s2.my    <= W_SUM'(prod_s1[4]) + W_SUM'(prod_s1[5])
				+ W_SUM'(prod_s1[6]) + W_SUM'(prod_s1[7]);
		end
	end

	assign cell_out = cell_s2;

endmodule

@@ src/omr_cordic_cell.sv @@
// One rotation cell of the CORDIC chain, carrying the body velocity along
// beside the vector. Uses omr_pkg for the cell type and arctangent table.
module omr_cordic_cell
	import omr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [STAGE_IDX_W-1:0] stage_idx,
	input  cell_t                  cell_in,
	output cell_t                  cell_out
);

	logic signed [W_CORD-1:0] dx;
	logic signed [W_CORD-1:0] dy;
	logic signed [W_CORD-1:0] ang;
	cell_t                    stage_q;

	assign dx  = cell_in.y >>> stage_idx;
	assign dy  = cell_in.x >>> stage_idx;
	assign ang = atan_angle(stage_idx);

	// A residual angle of zero steers as a positive one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
		end else if (en) begin
			stage_q.valid <= cell_in.valid;
			stage_q.flip  <= cell_in.flip;
			stage_q.mx    <= cell_in.mx;
			stage_q.my    <= cell_in.my;
			if (!cell_in.z[W_CORD-1]) begin
				stage_q.x <= cell_in.x - dx;
				stage_q.y <= cell_in.y + dy;
				stage_q.z <= cell_in.z - ang;
			end else begin
				stage_q.x <= cell_in.x + dx;
				stage_q.y <= cell_in.y - dy;
				stage_q.z <= cell_in.z + ang;
			end
		end
	end

	assign cell_out = stage_q;

endmodule

@@ src/omr_rotate.sv @@
// Rounds the CORDIC cosine and sine, rotates the body velocity into the
// world frame and rounds and saturates to Q12.8. Uses omr_pkg.
module omr_rotate
	import omr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  cell_t     cell_in,
	output logic      res_valid,
	output out_item_t res_item
);

	localparam logic signed [W_ACC-1:0] RND_HALF = W_ACC'(64'sd1 <<< 29);

	logic signed [W_CORD-1:0] cx;
	logic signed [W_CORD-1:0] sy;
	logic signed [W_CORD-1:0] cx_rnd;
	logic signed [W_CORD-1:0] sy_rnd;

	logic                    valid_s1, valid_s2, valid_s3;
	logic signed [W_CS-1:0]  cos_s1, sin_s1;
	logic signed [W_SUM-1:0] mx_s1, my_s1;
	logic signed [W_ROT-1:0] pcx_s2, psy_s2, psx_s2, pcy_s2;
	logic signed [W_ACC-1:0] vx_s3, vy_s3;
	logic signed [W_ACC-1:0] vx_rnd, vy_rnd;
	logic signed [W_RND-1:0] vx_q8, vy_q8;

	assign cx     = cell_in.flip ? -cell_in.x : cell_in.x;
	assign sy     = cell_in.flip ? -cell_in.y : cell_in.y;
	assign cx_rnd = cx + 33'sd8192;
	assign sy_rnd = sy + 33'sd8192;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= cell_in.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s1 <= cx_rnd[W_CORD-1:14];
			sin_s1 <= sy_rnd[W_CORD-1:14];
			mx_s1  <= cell_in.mx;
			my_s1  <= cell_in.my;
			pcx_s2 <= cos_s1 * mx_s1;
			psy_s2 <= sin_s1 * my_s1;
			psx_s2 <= sin_s1 * mx_s1;
			pcy_s2 <= cos_s1 * my_s1;
			vx_s3  <= W_ACC'(pcx_s2) - W_ACC'(psy_s2);
			vy_s3  <= W_ACC'(psx_s2) + W_ACC'(pcy_s2);
		end
	end

	// Add a half and floor, so that halves round upwards.
	assign vx_rnd = vx_s3 + RND_HALF;
	assign vy_rnd = vy_s3 + RND_HALF;
	assign vx_q8  = vx_rnd[W_ACC-1:30];
	assign vy_q8  = vy_rnd[W_ACC-1:30];

	always_comb begin
		if (vx_q8 > W_RND'(OUT_MAX)) begin
			res_item.vel_x = OUT_MAX;
		end else if (vx_q8 < W_RND'(OUT_MIN)) begin
			res_item.vel_x = OUT_MIN;
		end else begin
			res_item.vel_x = vx_q8[W_OUT-1:0];
		end
		if (vy_q8 > W_RND'(OUT_MAX)) begin
			res_item.vel_y = OUT_MAX;
		end else if (vy_q8 < W_RND'(OUT_MIN)) begin
			res_item.vel_y = OUT_MIN;
		end else begin
			res_item.vel_y = vy_q8[W_OUT-1:0];
		end
	end

	assign res_valid = valid_s3;

endmodule

@@ src/omni_wheel_odometry_rotate_top.sv @@
// Top level of the omni-wheel odometry rotate block: coefficient registers,
// matrix stage, CORDIC cell chain, rotation stage and output skid buffer.
// Depends on omr_pkg, omr_matrix, omr_cordic_cell and omr_rotate.
//
// Usage. Each input item carries four signed Q8.8 wheel speeds and a
// heading as a binary angle. The block multiplies the speeds by a 2x4
// kinematic matrix held in eight Q2.14 registers, rotates the resulting
// body velocity by the heading and returns one item holding the world
// velocity as signed Q12.8, rounded and saturated.
// Both channels use valid and stall; an item moves at an edge where valid
// is high and stall is low. The user must write the coefficient registers
// through cfg_wr_en, cfg_index and cfg_data only while no item is in
// flight; the block does not enforce this. An index above seven is ignored.
// From the accepting edge to out_valid an item passes two matrix
// stages, sixteen CORDIC cells, three rotation stages and the output
// register. One item is accepted every cycle while in_stall is low; the
// chain of cells is fully pipelined and sets that rate.
// Reset loads the default omni-wheel matrix and empties the pipeline.
// When the receiver stalls, the output register holds its item and the
// next finished item drops into a one-entry skid register; only once that
// is full does in_stall rise, freezing the whole pipeline in place.
module omni_wheel_odometry_rotate_top
	import omr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [W_IN-1:0]      cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item
);

	coef_arr_t coef_q;
	logic      pipe_en;
	logic      in_fire;
	cell_t     chain [CORDIC_STAGES + 1];
	logic      res_valid;
	out_item_t res_item;
	logic      out_valid_q;
	out_item_t out_item_q;
	logic      skid_valid_q;
	out_item_t skid_item_q;
	logic      out_take;

	// Coefficient registers; writes to unknown indices fall away.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
		end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_COEF))) begin
			coef_q[cfg_index[COEF_IDX_W-1:0]] <= cfg_data;
		end
	end

	// The pipeline moves whenever the skid register has room.
	assign pipe_en  = !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid && pipe_en;

	omr_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_fire  (in_fire),
		.item     (in_item),
		.coef     (coef_q),
		.cell_out (chain[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		omr_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (pipe_en),
			.stage_idx (STAGE_IDX_W'(i)),
			.cell_in   (chain[i]),
			.cell_out  (chain[i + 1])
		);
	end

	omr_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.cell_in   (chain[CORDIC_STAGES]),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	// Output register with a one-entry skid behind it. A finished item goes
	// straight to the output when that is free or being taken, otherwise
	// into the skid register.
	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pipe_en && res_valid) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en && res_valid) begin
			if (!out_valid_q || out_take) begin
				out_item_q <= res_item;
			end else begin
				skid_item_q <= res_item;
			end
		end else if (skid_valid_q && out_take) begin
			out_item_q <= skid_item_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !out_stall) |=> (out_valid_q && !skid_valid_q))
		else $error("skid register did not move into the output register");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid register filled without a stalled output");

	a_bad_index_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr_en && (cfg_index >= CFG_IDX_W'(NUM_COEF))) |=> $stable(coef_q))
		else $error("write to an unknown register index changed a coefficient");

endmodule
